>>> rtl/core/mmdec_pkg.sv
// mmdec_pkg: shared types, sizes and register indexes of the min/max decimator
// used by mmdec_cell, mmdec_serializer and multilevel_minmax_decimator_top
// no dependencies

package mmdec_pkg;

    // block sizes
    localparam int MAX_LEVELS   = 4;
    localparam int CHANNELS     = 16;
    localparam int SAMPLE_WIDTH = 16;

    // derived widths
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int LVL_IDX_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LVL_CNT_W   = $clog2(MAX_LEVELS + 1);
    localparam int STEP_MAX    = 1024;
    localparam int CNT_W       = $clog2(STEP_MAX);
    localparam int STEP_W      = CNT_W + 1;

    // register port
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 11;
    localparam int LEVEL_COUNT_W = 3;
    localparam int LEVEL_OUT_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_1      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_2      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_3      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_4      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED      = 3'd5;

    // one sample travelling down the row of cells with the pairs it completed
    typedef struct packed {
        logic                                      valid;
        logic [CH_W-1:0]                           channel;
        logic                                      chunk_end;
        logic                                      carry;
        logic [SAMPLE_WIDTH-1:0]                   mn;
        logic [SAMPLE_WIDTH-1:0]                   mx;
        logic [LVL_CNT_W-1:0]                      nres;
        logic [MAX_LEVELS-1:0][SAMPLE_WIDTH-1:0]   res_min;
        logic [MAX_LEVELS-1:0][SAMPLE_WIDTH-1:0]   res_max;
    } token_t;

    // settings seen by one cell
    typedef struct packed {
        logic [LVL_CNT_W-1:0] nlev;
        logic [STEP_W-1:0]    step;
        logic                 sgn;
    } cell_cfg_t;

    // flip the sign bit so that signed order becomes unsigned order
    function automatic logic [SAMPLE_WIDTH-1:0] order_key(
        input logic [SAMPLE_WIDTH-1:0] v,
        input logic                    sgn
    );
        logic [SAMPLE_WIDTH-1:0] k;
        k = v;
        k[SAMPLE_WIDTH-1] = v[SAMPLE_WIDTH-1] ^ sgn;
        return k;
    endfunction

endpackage

>>> rtl/core/multilevel_minmax_decimator_top.sv
// multilevel_minmax_decimator_top: per-channel cascade of min/max decimation levels
// depends on mmdec_pkg, mmdec_cell, mmdec_serializer

// Each accepted sample enters an input register and then walks a row of
// MAX_LEVELS cells, one cell per decimation level, one cell per cycle while the
// row advances. A cell keeps the open window (min, max, fill count) of every
// channel for its level and updates it in the cycle the sample passes, so
// samples of the same channel may follow each other in back-to-back cycles.
// Pairs a sample completes ride along with it and are handed out by the output
// register one transaction per cycle while m_ready is high, lowest level first,
// the last one flagged with m_last_of_run. Rate: one sample per cycle while each
// sample completes at most one pair and the receiver keeps m_ready high; a sample
// that completes several pairs holds the row of cells until its last pair is
// taken. Configuration writes are accepted in every cycle and must be made while
// the block is idle.

module multilevel_minmax_decimator_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mmdec_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mmdec_pkg::CFG_DATA_W-1:0]       cfg_data,
    // sample input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [mmdec_pkg::CH_W-1:0]             s_channel,
    input  logic [mmdec_pkg::SAMPLE_WIDTH-1:0]     s_sample,
    input  logic                                   s_chunk_end,
    // pair output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [mmdec_pkg::LEVEL_OUT_W-1:0]      m_level,
    output logic [mmdec_pkg::CH_W-1:0]             m_out_channel,
    output logic [mmdec_pkg::SAMPLE_WIDTH-1:0]     m_window_min,
    output logic [mmdec_pkg::SAMPLE_WIDTH-1:0]     m_window_max,
    output logic                                   m_last_of_run
);

    // configuration registers
    logic [mmdec_pkg::LEVEL_COUNT_W-1:0] level_count_reg;
    logic [mmdec_pkg::CFG_DATA_W-1:0]    step_reg [mmdec_pkg::MAX_LEVELS];
    logic                                signed_reg;

    // row of tokens: input register, then one per cell
    mmdec_pkg::token_t    tok_in_next;
    mmdec_pkg::token_t    tok_in_reg;
    mmdec_pkg::token_t    stage [mmdec_pkg::MAX_LEVELS+1];
    mmdec_pkg::cell_cfg_t cell_cfg [mmdec_pkg::MAX_LEVELS];
    logic [mmdec_pkg::LVL_CNT_W-1:0] nlev;
    logic                 advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_count_reg <= mmdec_pkg::LEVEL_COUNT_W'(1);
            for (int i = 0; i < mmdec_pkg::MAX_LEVELS; i++) begin
                step_reg[i] <= mmdec_pkg::CFG_DATA_W'(2);
            end
            signed_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mmdec_pkg::CFG_LEVEL_COUNT: begin
                    level_count_reg <= cfg_data[mmdec_pkg::LEVEL_COUNT_W-1:0];
                end
                mmdec_pkg::CFG_STEP_1: step_reg[0] <= cfg_data;
                mmdec_pkg::CFG_STEP_2: step_reg[1] <= cfg_data;
                mmdec_pkg::CFG_STEP_3: step_reg[2] <= cfg_data;
                mmdec_pkg::CFG_STEP_4: step_reg[3] <= cfg_data;
                mmdec_pkg::CFG_SIGNED: signed_reg  <= cfg_data[0];
                default: begin
                    // unused index, write is dropped
                end
            endcase
        end
    end

    // level count clamped to 1..MAX_LEVELS
    always_comb begin
        if (level_count_reg == '0) begin
            nlev = mmdec_pkg::LVL_CNT_W'(1);
        end else if (level_count_reg > mmdec_pkg::LEVEL_COUNT_W'(mmdec_pkg::MAX_LEVELS)) begin
            nlev = mmdec_pkg::LVL_CNT_W'(mmdec_pkg::MAX_LEVELS);
        end else begin
            nlev = mmdec_pkg::LVL_CNT_W'(level_count_reg);
        end
    end

    // per-cell settings, steps clamped to 1..STEP_MAX
    always_comb begin
        for (int i = 0; i < mmdec_pkg::MAX_LEVELS; i++) begin
            cell_cfg[i].nlev = nlev;
            cell_cfg[i].sgn  = signed_reg;
            if (step_reg[i] == '0) begin
                cell_cfg[i].step = mmdec_pkg::STEP_W'(1);
            end else if (mmdec_pkg::STEP_W'(step_reg[i]) >
                         mmdec_pkg::STEP_W'(mmdec_pkg::STEP_MAX)) begin
                cell_cfg[i].step = mmdec_pkg::STEP_W'(mmdec_pkg::STEP_MAX);
            end else begin
                cell_cfg[i].step = mmdec_pkg::STEP_W'(step_reg[i]);
            end
        end
    end

    // the whole row moves whenever the output register can take the tail
    assign s_ready = advance;

    // incoming sample starts as an open pair (sample, sample) with no results
    always_comb begin
        tok_in_next           = tok_in_reg;
        tok_in_next.valid     = s_valid;
        tok_in_next.channel   = s_channel;
        tok_in_next.chunk_end = s_chunk_end;
        tok_in_next.carry     = 1'b1;
        tok_in_next.mn        = s_sample;
        tok_in_next.mx        = s_sample;
        tok_in_next.nres      = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_in_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_in_reg <= tok_in_next;
        end
    end

    assign stage[0] = tok_in_reg;

    // one cell per level, each passing the sample to the next
    for (genvar g = 0; g < mmdec_pkg::MAX_LEVELS; g++) begin : g_cell
        mmdec_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .cell_level (mmdec_pkg::LVL_IDX_W'(g)),
            .cfg        (cell_cfg[g]),
            .tok_in     (stage[g]),
            .tok_out    (stage[g+1])
        );
    end

    // output register: one pair per transaction
    mmdec_serializer u_serializer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tail          (stage[mmdec_pkg::MAX_LEVELS]),
        .ser_free      (advance),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level       (m_level),
        .m_out_channel (m_out_channel),
        .m_window_min  (m_window_min),
        .m_window_max  (m_window_max),
        .m_last_of_run (m_last_of_run)
    );

endmodule

>>> rtl/core/mmdec_cell.sv
// mmdec_cell: one decimation level, holding the open window of every channel
// depends on mmdec_pkg

module mmdec_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [mmdec_pkg::LVL_IDX_W-1:0] cell_level,
    input  mmdec_pkg::cell_cfg_t          cfg,
    input  mmdec_pkg::token_t             tok_in,
    output mmdec_pkg::token_t             tok_out
);

    logic [mmdec_pkg::SAMPLE_WIDTH-1:0] min_reg [mmdec_pkg::CHANNELS];
    logic [mmdec_pkg::SAMPLE_WIDTH-1:0] max_reg [mmdec_pkg::CHANNELS];
    logic [mmdec_pkg::CNT_W-1:0]        cnt_reg [mmdec_pkg::CHANNELS];
    mmdec_pkg::token_t                  tok_reg;
    mmdec_pkg::token_t                  tok_next;

    logic [mmdec_pkg::CNT_W-1:0]        cnt;
    logic [mmdec_pkg::STEP_W-1:0]       cnt_inc;
    logic [mmdec_pkg::SAMPLE_WIDTH-1:0] old_min;
    logic [mmdec_pkg::SAMPLE_WIDTH-1:0] old_max;
    logic [mmdec_pkg::SAMPLE_WIDTH-1:0] new_min;
    logic [mmdec_pkg::SAMPLE_WIDTH-1:0] new_max;
    logic                               level_on;
    logic                               fold;
    logic                               first;
    logic                               lt;
    logic                               gt;
    logic                               done;

    always_comb begin
        cnt      = cnt_reg[tok_in.channel];
        old_min  = min_reg[tok_in.channel];
        old_max  = max_reg[tok_in.channel];
        level_on = mmdec_pkg::LVL_CNT_W'(cell_level) < cfg.nlev;
        fold     = tok_in.valid && tok_in.carry && level_on;
        first    = (cnt == '0);
        lt = mmdec_pkg::order_key(tok_in.mn, cfg.sgn) < mmdec_pkg::order_key(old_min, cfg.sgn);
        gt = mmdec_pkg::order_key(tok_in.mx, cfg.sgn) > mmdec_pkg::order_key(old_max, cfg.sgn);
        new_min  = (first || lt) ? tok_in.mn : old_min;
        new_max  = (first || gt) ? tok_in.mx : old_max;
        cnt_inc  = {1'b0, cnt} + mmdec_pkg::STEP_W'(1);
        done     = (cnt_inc >= cfg.step);

        tok_next       = tok_in;
        tok_next.carry = fold && done;
        if (fold && done) begin
            tok_next.mn                  = new_min;
            tok_next.mx                  = new_max;
            tok_next.res_min[cell_level] = new_min;
            tok_next.res_max[cell_level] = new_max;
            tok_next.nres = mmdec_pkg::LVL_CNT_W'(cell_level) + mmdec_pkg::LVL_CNT_W'(1);
        end
    end

    // window extremes: written by every sample folded into a window, no reset
    always_ff @(posedge aclk) begin
        if (advance && fold) begin
            min_reg[tok_in.channel] <= new_min;
            max_reg[tok_in.channel] <= new_max;
        end
    end

    // window fill counts, cleared when a window closes or a chunk end passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mmdec_pkg::CHANNELS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (advance && tok_in.valid) begin
            if (tok_in.chunk_end) begin
                cnt_reg[tok_in.channel] <= '0;
            end else if (fold) begin
                cnt_reg[tok_in.channel] <= done ? '0 : cnt_inc[mmdec_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/core/mmdec_serializer.sv
// mmdec_serializer: output register that hands out the pairs of one sample,
// one transaction per cycle while m_ready is high, lowest level first; depends on mmdec_pkg

module mmdec_serializer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mmdec_pkg::token_t                     tail,
    output logic                                  ser_free,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mmdec_pkg::LEVEL_OUT_W-1:0]     m_level,
    output logic [mmdec_pkg::CH_W-1:0]            m_out_channel,
    output logic [mmdec_pkg::SAMPLE_WIDTH-1:0]    m_window_min,
    output logic [mmdec_pkg::SAMPLE_WIDTH-1:0]    m_window_max,
    output logic                                  m_last_of_run
);

    mmdec_pkg::token_t                  hold_reg;
    logic                               valid_reg;
    logic [mmdec_pkg::LVL_IDX_W-1:0]    idx_reg;
    logic                               ser_last;

    assign ser_last = (mmdec_pkg::LVL_CNT_W'(idx_reg) + mmdec_pkg::LVL_CNT_W'(1))
                      == hold_reg.nres;
    assign ser_free = !valid_reg || (m_ready && ser_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (ser_free) begin
            valid_reg <= tail.valid && (tail.nres != '0);
            idx_reg   <= '0;
        end else if (m_ready) begin
            idx_reg   <= idx_reg + mmdec_pkg::LVL_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_free) begin
            hold_reg <= tail;
        end
    end

    assign m_valid       = valid_reg;
    assign m_level       = mmdec_pkg::LEVEL_OUT_W'(idx_reg) + mmdec_pkg::LEVEL_OUT_W'(1);
    assign m_out_channel = hold_reg.channel;
    assign m_window_min  = hold_reg.res_min[idx_reg];
    assign m_window_max  = hold_reg.res_max[idx_reg];
    assign m_last_of_run = ser_last;

endmodule

>>> test/tb_multilevel_minmax_decimator_top.sv
// tb_multilevel_minmax_decimator_top: self-checking bench for the min/max decimation cascade
// keeps its own per-channel window model and checks every pair the block hands out
// depends on mmdec_pkg and multilevel_minmax_decimator_top
`timescale 1ns / 100ps

module tb_multilevel_minmax_decimator_top;

    import mmdec_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    // spare register indexes, the block must ignore writes to them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

    // cycles with no transaction on any channel before the run is declared hung
    localparam int STALL_LIMIT  = 2000;
    // long receiver hold-off that backs the cascade up into the input
    localparam int LONG_HOLD    = 300;
    // margin after the last pair before a register write
    localparam int DRAIN_CYCLES = 16;
    localparam int TAIL_CYCLES  = 32;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 25;
    // samples folded into the long window before its step is lowered
    localparam int LONG_ITEMS   = 40;
    localparam logic [CH_W-1:0] LONG_CH = 4'd9;

    // one pair as it leaves the block
    typedef struct packed {
        logic [LEVEL_OUT_W-1:0] level;
        logic [CH_W-1:0]        channel;
        logic [SW-1:0]          lo;
        logic [SW-1:0]          hi;
        logic                   ends_run;
    } pair_t;

    // directed script: a sample or a register write, a sample may carry a fixed answer
    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CH_W-1:0]        channel;
        logic [SW-1:0]          sample;
        logic                   chunk_end;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic                   fixed;
        pair_t                  pair;
    } row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [CH_W-1:0]        s_channel;
    logic [SW-1:0]          s_sample;
    logic                   s_chunk_end;
    logic                   m_valid;
    logic                   m_ready;
    logic [LEVEL_OUT_W-1:0] m_level;
    logic [CH_W-1:0]        m_out_channel;
    logic [SW-1:0]          m_window_min;
    logic [SW-1:0]          m_window_max;
    logic                   m_last_of_run;

    // fixed answer travelling with the sample currently offered
    logic  row_fixed;
    pair_t row_pair;

    // register mirror, reset values of the block
    logic [LEVEL_COUNT_W-1:0] set_levels = 3'd1;
    logic [CFG_DATA_W-1:0]    set_step [MAX_LEVELS] = '{default: 11'd2};
    logic                     set_signed = 1'b1;

    // open window per channel and level
    logic [SW-1:0] win_lo   [CHANNELS*MAX_LEVELS];
    logic [SW-1:0] win_hi   [CHANNELS*MAX_LEVELS];
    int unsigned   win_fill [CHANNELS*MAX_LEVELS] = '{default: 0};

    pair_t fresh_pairs[$];    // pairs completed by the sample just folded
    pair_t pending_pairs[$];  // pairs owed by the block, oldest first
    pair_t oldest_pair;
    row_t  script[$];

    int          mismatches = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int          hold_requests = 0;

    multilevel_minmax_decimator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .s_chunk_end   (s_chunk_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level       (m_level),
        .m_out_channel (m_out_channel),
        .m_window_min  (m_window_min),
        .m_window_max  (m_window_max),
        .m_last_of_run (m_last_of_run)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // window model
    // ---------------------------------------------------------------

    // compare key: with signed compare the sign bit is flipped
    function automatic logic [SW-1:0] rank(input logic [SW-1:0] v);
        logic [SW-1:0] k;
        k = v;
        k[SW-1] = v[SW-1] ^ set_signed;
        return k;
    endfunction

    // elements per window at a level, zero reads as one, large values saturate
    function automatic int unsigned window_len(input int lvl);
        int unsigned s;
        s = set_step[lvl];
        if (s == 0) s = 1;
        if (s > STEP_MAX) s = STEP_MAX;
        return s;
    endfunction

    function automatic int active_levels();
        int n;
        n = set_levels;
        if (n == 0) n = 1;
        if (n > MAX_LEVELS) n = MAX_LEVELS;
        return n;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_LEVEL_COUNT: set_levels = data[LEVEL_COUNT_W-1:0];
            CFG_STEP_1:      set_step[0] = data;
            CFG_STEP_2:      set_step[1] = data;
            CFG_STEP_3:      set_step[2] = data;
            CFG_STEP_4:      set_step[3] = data;
            CFG_SIGNED:      set_signed = data[0];
            default: ;
        endcase
    endfunction

    // fold one sample up the cascade, each closed window feeds the level above
    function automatic void fold_sample(input logic [CH_W-1:0] ch, input logic [SW-1:0] smp,
                                        input logic chunk_end);
        logic [SW-1:0] lo;
        logic [SW-1:0] hi;
        int            lvl;
        int            e;
        int            nlev;
        bit            closed;
        pair_t         p;
        lo = smp;
        hi = smp;
        nlev = active_levels();
        closed = 1'b1;
        fresh_pairs.delete();
        for (lvl = 0; lvl < nlev && closed; lvl++) begin
            e = ch * MAX_LEVELS + lvl;
            if (win_fill[e] == 0) begin
                // first element of a window overwrites whatever was there
                win_lo[e] = lo;
                win_hi[e] = hi;
            end else begin
                if (rank(lo) < rank(win_lo[e])) win_lo[e] = lo;
                if (rank(hi) > rank(win_hi[e])) win_hi[e] = hi;
            end
            win_fill[e]++;
            closed = (win_fill[e] >= window_len(lvl));
            if (closed) begin
                win_fill[e] = 0;
                lo = win_lo[e];
                hi = win_hi[e];
                p.level = LEVEL_OUT_W'(lvl + 1);
                p.channel = ch;
                p.lo = lo;
                p.hi = hi;
                p.ends_run = 1'b0;
                fresh_pairs.push_back(p);
            end
        end
        if (fresh_pairs.size() != 0) begin
            p = fresh_pairs.pop_back();
            p.ends_run = 1'b1;
            fresh_pairs.push_back(p);
        end
        // chunk end drops every open window of the channel, pairs above included
        if (chunk_end) begin
            for (lvl = 0; lvl < MAX_LEVELS; lvl++) win_fill[ch * MAX_LEVELS + lvl] = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // transaction monitor and checker
    // ---------------------------------------------------------------

    // everything is sampled at the edge, all drivers use nonblocking updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                fold_sample(s_channel, s_sample, s_chunk_end);
                if (row_fixed) pending_pairs.push_back(row_pair);
                else foreach (fresh_pairs[i]) pending_pairs.push_back(fresh_pairs[i]);
            end
            if (m_valid && m_ready) begin
                if (pending_pairs.size() == 0) begin
                    $error("unexpected pair: level %0d channel %0d min %h max %h",
                           m_level, m_out_channel, m_window_min, m_window_max);
                    mismatches++;
                end else begin
                    oldest_pair = pending_pairs.pop_front();
                    if (m_level !== oldest_pair.level) begin
                        $error("level: expected %0d, got %0d", oldest_pair.level, m_level);
                        mismatches++;
                    end
                    if (m_out_channel !== oldest_pair.channel) begin
                        $error("out_channel: expected %0d, got %0d",
                               oldest_pair.channel, m_out_channel);
                        mismatches++;
                    end
                    if (m_window_min !== oldest_pair.lo) begin
                        $error("window_min: expected %h, got %h", oldest_pair.lo, m_window_min);
                        mismatches++;
                    end
                    if (m_window_max !== oldest_pair.hi) begin
                        $error("window_max: expected %h, got %h", oldest_pair.hi, m_window_max);
                        mismatches++;
                    end
                    if (m_last_of_run !== oldest_pair.ends_run) begin
                        $error("last_of_run: expected %0d, got %0d",
                               oldest_pair.ends_run, m_last_of_run);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------

    initial begin : result_sink
        int held;
        int holds_served;
        holds_served = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // watchdog: no transaction anywhere for too long ends the run
    // ---------------------------------------------------------------

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_multilevel_minmax_decimator_top: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // driver tasks
    // ---------------------------------------------------------------

    // offer one sample, valid stays up across back-to-back transactions
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SW-1:0] smp,
                               input logic chunk_end, input logic fixed, input pair_t answer);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid     <= 1'b1;
        s_channel   <= ch;
        s_sample    <= smp;
        s_chunk_end <= chunk_end;
        row_fixed   <= fixed;
        row_pair    <= answer;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait until the block has nothing left to hand out, let the pipe empty, then write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pairs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // extremes of the sample code show up often
    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return {1'b0, {(SW-1){1'b1}}};
            2:       return {1'b1, {(SW-1){1'b0}}};
            3:       return '1;
            default: return SW'($urandom());
        endcase
    endfunction

    // mostly short steps so pairs come often, now and then anything the field holds
    function automatic logic [CFG_DATA_W-1:0] upper_step();
        if ($urandom_range(9) == 0) return CFG_DATA_W'($urandom_range(2047));
        return CFG_DATA_W'($urandom_range(3));
    endfunction

    // ---------------------------------------------------------------
    // directed script
    // ---------------------------------------------------------------

    function automatic void sample_row(input logic [CH_W-1:0] ch, input logic [SW-1:0] smp,
                                       input logic chunk_end);
        row_t r;
        r = '{kind: ROW_SAMPLE, channel: ch, sample: smp, chunk_end: chunk_end,
              reg_index: '0, reg_data: '0, fixed: 1'b0, pair: '0};
        script.push_back(r);
    endfunction

    // sample whose single pair is written out here
    function automatic void checked_row(input logic [CH_W-1:0] ch, input logic [SW-1:0] smp,
                                        input logic chunk_end, input logic [LEVEL_OUT_W-1:0] lvl,
                                        input logic [SW-1:0] lo, input logic [SW-1:0] hi);
        row_t r;
        r = '{kind: ROW_SAMPLE, channel: ch, sample: smp, chunk_end: chunk_end,
              reg_index: '0, reg_data: '0, fixed: 1'b1, pair: '0};
        r.pair.level = lvl;
        r.pair.channel = ch;
        r.pair.lo = lo;
        r.pair.hi = hi;
        r.pair.ends_run = 1'b1;
        script.push_back(r);
    endfunction

    function automatic void reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        row_t r;
        r = '{kind: ROW_REG, channel: '0, sample: '0, chunk_end: 1'b0,
              reg_index: idx, reg_data: data, fixed: 1'b0, pair: '0};
        script.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin : stimulus
        int              phase;
        logic [CH_W-1:0] hot_a;
        logic [CH_W-1:0] hot_b;
        logic [CH_W-1:0] ch;
        pair_t           no_pair;

        no_pair     = '0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_channel   = '0;
        s_sample    = '0;
        s_chunk_end = 1'b0;
        row_fixed   = 1'b0;
        row_pair    = '0;

        // reset settings: one level, windows of two, signed compare
        sample_row (4'd0,  16'h7FFF, 1'b0);
        checked_row(4'd0,  16'h8000, 1'b0, 3'd1, 16'h8000, 16'h7FFF);
        sample_row (4'd15, 16'hFFFF, 1'b0);
        checked_row(4'd15, 16'h0000, 1'b0, 3'd1, 16'hFFFF, 16'h0000);
        // unsigned compare turns the same codes around
        reg_row    (CFG_SIGNED, 11'd0);
        sample_row (4'd1,  16'hFFFF, 1'b0);
        checked_row(4'd1,  16'h0000, 1'b0, 3'd1, 16'h0000, 16'hFFFF);
        // chunk end on an open window throws the window away
        sample_row (4'd2,  16'h1234, 1'b1);
        sample_row (4'd2,  16'h0005, 1'b0);
        checked_row(4'd2,  16'h0007, 1'b0, 3'd1, 16'h0005, 16'h0007);
        // chunk end on the closing sample still hands out the pair
        sample_row (4'd3,  16'h0010, 1'b0);
        checked_row(4'd3,  16'h0020, 1'b1, 3'd1, 16'h0010, 16'h0020);
        sample_row (4'd3,  16'h0030, 1'b0);
        // four levels of unit windows: one sample, four pairs
        reg_row    (CFG_LEVEL_COUNT, 11'd4);
        reg_row    (CFG_STEP_1, 11'd1);
        reg_row    (CFG_STEP_2, 11'd1);
        reg_row    (CFG_STEP_3, 11'd1);
        reg_row    (CFG_STEP_4, 11'd1);
        sample_row (4'd4,  16'hABCD, 1'b0);
        // level count of zero runs one level
        reg_row    (CFG_LEVEL_COUNT, 11'd0);
        checked_row(4'd5,  16'h0001, 1'b0, 3'd1, 16'h0001, 16'h0001);
        // level count past the maximum runs all of them, zero step acts as one
        reg_row    (CFG_LEVEL_COUNT, 11'd7);
        reg_row    (CFG_STEP_1, 11'd0);
        sample_row (4'd5,  16'h0002, 1'b0);
        // a level switched off keeps its open window until it is used again
        reg_row    (CFG_LEVEL_COUNT, 11'd2);
        reg_row    (CFG_STEP_2, 11'd2);
        sample_row (4'd7,  16'h0100, 1'b0);
        reg_row    (CFG_LEVEL_COUNT, 11'd1);
        sample_row (4'd7,  16'h0300, 1'b0);
        reg_row    (CFG_LEVEL_COUNT, 11'd2);
        sample_row (4'd7,  16'h0200, 1'b1);
        // writes past the last register change nothing
        reg_row    (CFG_SPARE_6, 11'h7FF);
        reg_row    (CFG_SPARE_7, 11'h7FF);
        sample_row (4'd8,  16'h5555, 1'b0);
        sample_row (4'd8,  16'hAAAA, 1'b0);
        reg_row    (CFG_SIGNED, 11'd1);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part under light sender gaps and a slow receiver
        tx_idle_pct  = 19;
        rx_stall_pct = 83;
        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                write_reg(script[i].reg_index, script[i].reg_data);
            end else begin
                send_sample(script[i].channel, script[i].sample, script[i].chunk_end,
                            script[i].fixed, script[i].pair);
            end
        end

        // largest step code saturates, so the window stays open through many samples,
        // then a lowered step closes the partly filled window on its next sample
        write_reg(CFG_LEVEL_COUNT, 11'd1);
        write_reg(CFG_STEP_1, 11'h7FF);
        write_reg(CFG_STEP_2, CFG_DATA_W'(STEP_MAX));
        repeat (LONG_ITEMS) send_sample(LONG_CH, pick_sample(), 1'b0, 1'b0, no_pair);
        write_reg(CFG_STEP_1, 11'd3);
        send_sample(LONG_CH, pick_sample(), 1'b0, 1'b0, no_pair);

        // random phases: two busy channels per phase so upper levels close too
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    tx_idle_pct  = 19;
                    rx_stall_pct = 83;
                end
                1: begin
                    tx_idle_pct  = 83;
                    rx_stall_pct = 19;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            write_reg(CFG_LEVEL_COUNT, ($urandom_range(7) == 0) ?
                      CFG_DATA_W'($urandom_range(7)) : CFG_DATA_W'($urandom_range(1, 4)));
            write_reg(CFG_STEP_1, CFG_DATA_W'($urandom_range(3)));
            write_reg(CFG_STEP_2, upper_step());
            write_reg(CFG_STEP_3, upper_step());
            write_reg(CFG_STEP_4, upper_step());
            write_reg(CFG_SIGNED, CFG_DATA_W'($urandom_range(1)));
            hot_a = CH_W'($urandom_range(15));
            hot_b = CH_W'($urandom_range(15));
            // last phase: receiver holds off while the sender keeps offering
            if (phase == PHASES - 1) hold_requests++;
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(4) == 0) ch = CH_W'($urandom_range(15));
                else ch = $urandom_range(1) ? hot_a : hot_b;
                send_sample(ch, pick_sample(), ($urandom_range(19) == 0), 1'b0, no_pair);
            end
        end

        // drain: every owed pair must show up, then watch a while for strays
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pairs.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_pairs.size() == 0) begin
            $display("tb_multilevel_minmax_decimator_top: clean");
        end else begin
            $display("tb_multilevel_minmax_decimator_top: errors");
        end
        $finish;
    end

endmodule
